@@ hw/rtl/apr_pkg.sv @@
// Shared types, constants and tables for the axis-angle point rotator.
// No dependencies; every other file of the block imports this package.
package apr_pkg;

    localparam int MATRIX_FRAC_BITS = 30;
    localparam int CORDIC_STEPS     = 24;
    localparam int STEP_W           = $clog2(CORDIC_STEPS);
    localparam int DEN_W            = 32 + 30 - MATRIX_FRAC_BITS;
    localparam int SQRT_STEPS       = 32;

    localparam logic signed [26:0] ANG_FULL    = 27'sd23592960;
    localparam logic signed [26:0] ANG_QUARTER = 27'sd5898240;
    localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
    localparam logic [63:0]        RAD_DEN     = 64'd5898240;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic [63:0]        ENTRY_LIM   = 64'd1 << MATRIX_FRAC_BITS;

    // RAD_DEN is 45 << 17; divide by 45 through ceil(2^32 / 45)
    localparam int                 RAD_SHIFT   = 17;
    localparam logic [5:0]         RAD_ODD     = 6'd45;
    localparam logic signed [33:0] RAD_RECIP   = 34'sd95443718;

    localparam logic [1:0] REG_ANGLE  = 2'd0;
    localparam logic [1:0] REG_AXIS_U = 2'd1;
    localparam logic [1:0] REG_AXIS_V = 2'd2;
    localparam logic [1:0] REG_AXIS_W = 2'd3;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               clipped;
        logic               axis_error;
        logic               last_out;
    } result_t;

    typedef struct packed {
        logic signed [25:0] angle_deg;
        logic signed [15:0] axis_u;
        logic signed [15:0] axis_v;
        logic signed [15:0] axis_w;
    } cfg_t;

    typedef enum logic [4:0] {
        B_IDLE, B_PAIRS, B_LSUM, B_WRAP, B_QUAD, B_RADMUL, B_RADGO, B_RADWAIT,
        B_CORDIC, B_SIGNS, B_SQRT, B_SSMUL, B_SSRND, B_NUMA, B_NUMB, B_NUMSUM,
        B_DIVGO, B_DIVWAIT
    } bld_state_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd7;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/apr_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on apr_pkg for the divisor width.
module apr_div
    import apr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             start,
    input  logic [63:0]      dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [63:0]      quotient,
    output logic             done
);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [63:0]      q_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clear)
            begin
                busy_reg <= 1'b0;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

@@ hw/rtl/apr_build.sv @@
// Matrix builder: angle reduction, CORDIC, integer square root and the nine
// rounded divisions, on a main and a sine-term multiplier. Uses apr_pkg, apr_div.
module apr_build
    import apr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             cfg_write,
    input  logic             build_req,
    output logic             mat_ready,
    output logic [8:0][31:0] rot
);

    bld_state_t state_reg, state_next;

    logic                    ready_reg;
    logic [8:0][31:0]        rot_reg;
    logic signed [26:0]      ang_reg;
    logic [1:0]              quad_reg;
    logic signed [33:0]      x_reg, y_reg, z_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [33:0]      sin_reg, cos_reg, t_reg;
    logic signed [31:0]      uu_reg, vv_reg, ww_reg, uv_reg, uw_reg, vw_reg;
    logic [31:0]             l_reg;
    logic [63:0]             sqn_reg, sqres_reg, sqbit_reg;
    logic [4:0]              sqcnt_reg;
    logic signed [47:0]      ss_reg;
    logic [3:0]              k_reg;
    logic signed [67:0]      pa_reg, pc_reg, num_reg;
    logic signed [64:0]      pb_reg;
    logic                    neg_reg;
    logic [16:0]             qa_reg;

    logic signed [33:0]      mul_a, mul_b;
    logic signed [67:0]      mul_p;
    logic signed [16:0]      f_sel;
    logic signed [64:0]      mulb_p;
    logic                    div_start;
    logic [63:0]             div_dividend;
    logic [DEN_W-1:0]        div_divisor;
    logic [DEN_W-1:0]        den_l;
    logic [63:0]             quot;
    logic                    div_done;
    logic [63:0]             quot_c;
    logic [67:0]             mag;
    logic                    is_diag;
    logic signed [33:0]      sq_sel, pair_sel;
    logic signed [33:0]      dx, dy;
    logic [63:0]             sq_try;
    logic [36:0]             rad_n;
    logic [16:0]             rad_rem;
    logic [33:0]             rad_quot;

    apr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_write),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quot),
        .done     (div_done)
    );

    assign den_l = DEN_W'(l_reg) << (30 - MATRIX_FRAC_BITS);
    assign mag   = num_reg[67] ? 68'(-num_reg) : 68'(num_reg);
    assign quot_c = (quot > ENTRY_LIM) ? ENTRY_LIM : quot;
    assign dx    = y_reg >>> step_reg;
    assign dy    = x_reg >>> step_reg;
    assign sq_try = sqres_reg + sqbit_reg;

    // angle numerator over 2^17; divide the rest by 45 in two reciprocal
    // steps, upper bits first, carrying the remainder into the lower part
    assign rad_n    = 37'((pa_reg + 68'(RAD_DEN >> 1)) >>> RAD_SHIFT);
    assign rad_rem  = rad_n[36:20] - 17'(qa_reg * RAD_ODD);
    assign rad_quot = {2'b00, qa_reg[11:0], 20'd0} + 34'(mul_p[52:32]);

    // per-entry operand selection, row-major
    always_comb
    begin
        is_diag  = 1'b0;
        sq_sel   = '0;
        pair_sel = '0;
        f_sel    = '0;
        case (k_reg)
            4'd0: begin is_diag = 1'b1; sq_sel = 34'(uu_reg); end
            4'd1: begin pair_sel = 34'(uv_reg); f_sel = -17'(cfg.axis_w); end
            4'd2: begin pair_sel = 34'(uw_reg); f_sel = 17'(cfg.axis_v); end
            4'd3: begin pair_sel = 34'(uv_reg); f_sel = 17'(cfg.axis_w); end
            4'd4: begin is_diag = 1'b1; sq_sel = 34'(vv_reg); end
            4'd5: begin pair_sel = 34'(vw_reg); f_sel = -17'(cfg.axis_u); end
            4'd6: begin pair_sel = 34'(uw_reg); f_sel = -17'(cfg.axis_v); end
            4'd7: begin pair_sel = 34'(vw_reg); f_sel = 17'(cfg.axis_u); end
            4'd8: begin is_diag = 1'b1; sq_sel = 34'(ww_reg); end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_write)
        begin
            state_next = B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE:    if (build_req && !ready_reg) state_next = B_PAIRS;
                B_PAIRS:   state_next = B_LSUM;
                B_LSUM:    state_next = B_WRAP;
                B_WRAP:
                begin
                    if (l_reg == 32'd0)
                        state_next = B_IDLE;
                    else if (ang_reg >= 27'sd0 && ang_reg < ANG_FULL)
                        state_next = B_QUAD;
                end
                B_QUAD:    if (ang_reg < ANG_QUARTER) state_next = B_RADMUL;
                B_RADMUL:  state_next = B_RADGO;
                B_RADGO:   state_next = B_RADWAIT;
                B_RADWAIT: state_next = B_CORDIC;
                B_CORDIC:
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = B_SIGNS;
                B_SIGNS:   state_next = B_SQRT;
                B_SQRT:
                    if (sqcnt_reg == 5'(SQRT_STEPS - 1)) state_next = B_SSMUL;
                B_SSMUL:   state_next = B_SSRND;
                B_SSRND:   state_next = B_NUMA;
                B_NUMA:    state_next = B_NUMB;
                B_NUMB:    state_next = B_NUMSUM;
                B_NUMSUM:  state_next = B_DIVGO;
                B_DIVGO:   state_next = B_DIVWAIT;
                B_DIVWAIT:
                    if (div_done) state_next = (k_reg == 4'd8) ? B_IDLE : B_NUMA;
                default:   state_next = B_IDLE;
            endcase
        end
    end

    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = den_l;
        case (state_reg)
            B_RADMUL:
            begin
                mul_a = 34'(ang_reg);
                mul_b = PI_Q29;
            end
            B_RADGO:
            begin
                mul_a = $signed({17'd0, rad_n[36:20]});
                mul_b = RAD_RECIP;
            end
            B_RADWAIT:
            begin
                mul_a = $signed({8'd0, rad_rem[5:0], rad_n[19:0]});
                mul_b = RAD_RECIP;
            end
            B_SSMUL:
            begin
                mul_a = $signed({1'b0, sqres_reg[32:0]});
                mul_b = sin_reg;
            end
            B_NUMA:
            begin
                mul_a = is_diag ? sq_sel : pair_sel;
                mul_b = is_diag ? ONE_Q30 : t_reg;
            end
            B_NUMB:
            begin
                mul_a = is_diag ? 34'($signed({2'b00, l_reg}) - sq_sel) : 34'sd0;
                mul_b = is_diag ? cos_reg : 34'sd0;
            end
            B_DIVGO:
            begin
                div_start    = 1'b1;
                div_dividend = mag[63:0] + 64'(den_l >> 1);
            end
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign mulb_p = f_sel * ss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ready_reg <= 1'b0;
            rot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
                ready_reg <= 1'b0;
            else if (state_reg == B_WRAP && l_reg == 32'd0)
                ready_reg <= 1'b1;
            else if (state_reg == B_DIVWAIT && div_done && k_reg == 4'd8)
                ready_reg <= 1'b1;
            if (state_reg == B_IDLE && state_next == B_PAIRS)
                rot_reg <= '0;
            else if (state_reg == B_DIVWAIT && div_done)
                rot_reg[k_reg] <= neg_reg ? 32'(-quot_c) : quot_c[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_PAIRS:
            begin
                uu_reg  <= cfg.axis_u * cfg.axis_u;
                vv_reg  <= cfg.axis_v * cfg.axis_v;
                ww_reg  <= cfg.axis_w * cfg.axis_w;
                uv_reg  <= cfg.axis_u * cfg.axis_v;
                uw_reg  <= cfg.axis_u * cfg.axis_w;
                vw_reg  <= cfg.axis_v * cfg.axis_w;
                ang_reg <= 27'(cfg.angle_deg);
                quad_reg <= '0;
                k_reg   <= '0;
            end
            B_LSUM:
                l_reg <= 32'(uu_reg) + 32'(vv_reg) + 32'(ww_reg);
            B_WRAP:
            begin
                if (ang_reg < 27'sd0)
                    ang_reg <= ang_reg + ANG_FULL;
                else if (ang_reg >= ANG_FULL)
                    ang_reg <= ang_reg - ANG_FULL;
            end
            B_QUAD:
            begin
                if (ang_reg >= ANG_QUARTER)
                begin
                    ang_reg  <= ang_reg - ANG_QUARTER;
                    quad_reg <= quad_reg + 2'd1;
                end
            end
            B_RADMUL:
                pa_reg <= mul_p;
            B_RADGO:
                qa_reg <= mul_p[48:32];
            B_RADWAIT:
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= $signed(rad_quot);
                step_reg <= '0;
            end
            B_CORDIC:
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (z_reg >= 34'sd0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_entry(5'(step_reg));
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_entry(5'(step_reg));
                end
            end
            B_SIGNS:
            begin
                case (quad_reg)
                    2'd0: begin sin_reg <= y_reg;  cos_reg <= x_reg;  t_reg <= ONE_Q30 - x_reg; end
                    2'd1: begin sin_reg <= x_reg;  cos_reg <= -y_reg; t_reg <= ONE_Q30 + y_reg; end
                    2'd2: begin sin_reg <= -y_reg; cos_reg <= -x_reg; t_reg <= ONE_Q30 + x_reg; end
                    default:
                    begin
                        sin_reg <= -x_reg; cos_reg <= y_reg; t_reg <= ONE_Q30 - y_reg;
                    end
                endcase
                sqn_reg   <= {l_reg, 32'd0};
                sqres_reg <= '0;
                sqbit_reg <= 64'd1 << 62;
                sqcnt_reg <= '0;
            end
            B_SQRT:
            begin
                if (sqn_reg >= sq_try)
                begin
                    sqn_reg   <= sqn_reg - sq_try;
                    sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                end
                else
                begin
                    sqres_reg <= sqres_reg >> 1;
                end
                sqbit_reg <= sqbit_reg >> 2;
                sqcnt_reg <= sqcnt_reg + 5'd1;
            end
            B_SSMUL:
                pa_reg <= mul_p;
            B_SSRND:
                ss_reg <= 48'((pa_reg + 68'sd32768) >>> 16);
            B_NUMA:
            begin
                pa_reg <= mul_p;
                pb_reg <= mulb_p;
            end
            B_NUMB:
                pc_reg <= mul_p;
            B_NUMSUM:
                num_reg <= pa_reg + 68'(pb_reg) + pc_reg;
            B_DIVGO:
                neg_reg <= num_reg[67];
            B_DIVWAIT:
                if (div_done) k_reg <= k_reg + 4'd1;
            default: ;
        endcase
    end

    assign mat_ready = ready_reg;
    assign rot       = rot_reg;

endmodule

@@ hw/rtl/apr_mac.sv @@
// Three-stage point pipeline: products, rounded column sums, saturation.
// Uses apr_pkg; advances as one unit under the output stall.
module apr_mac
    import apr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_take,
    input  point_t           pt,
    input  logic             err,
    input  logic [8:0][31:0] rot,
    output logic             res_valid,
    output result_t          res
);

    localparam logic signed [65:0] RND  = 66'sd1 <<< (MATRIX_FRAC_BITS - 1);
    localparam logic signed [65:0] SMAX = 66'sd2147483647;
    localparam logic signed [65:0] SMIN = -66'sd2147483648;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [63:0]       prod_reg [9];
    logic [1:0]               flag1_reg, flag2_reg;
    logic signed [65:0]       sum_reg [3];
    logic signed [31:0]       p_in [3];
    logic signed [65:0]       acc [3];
    logic signed [31:0]       sat [3];
    logic [2:0]               clip;
    result_t                  res_reg;

    assign p_in[0] = pt.point_x;
    assign p_in[1] = pt.point_y;
    assign p_in[2] = pt.point_z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            acc[j] = 66'(prod_reg[j]) + 66'(prod_reg[3 + j]) + 66'(prod_reg[6 + j]) + RND;
            clip[j] = 1'b0;
            if (sum_reg[j] > SMAX)
            begin
                sat[j]  = 32'sh7fffffff;
                clip[j] = 1'b1;
            end
            else if (sum_reg[j] < SMIN)
            begin
                sat[j]  = 32'sh80000000;
                clip[j] = 1'b1;
            end
            else
            begin
                sat[j] = sum_reg[j][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod_reg[3 * i + j] <= p_in[i] * $signed(rot[3 * i + j]);
            flag1_reg <= {err, pt.last_point};
            for (int j = 0; j < 3; j++)
                sum_reg[j] <= acc[j] >>> MATRIX_FRAC_BITS;
            flag2_reg <= flag1_reg;
            res_reg.out_x      <= sat[0];
            res_reg.out_y      <= sat[1];
            res_reg.out_z      <= sat[2];
            res_reg.clipped    <= |clip;
            res_reg.axis_error <= flag2_reg[1];
            res_reg.last_out   <= flag2_reg[0];
        end
    end

    assign res_valid = v3_reg;
    assign res       = res_reg;

endmodule

@@ hw/rtl/axis_angle_point_rotator_unit.sv @@
// Axis-angle point rotator: holds the configuration registers, builds the
// rotation matrix on demand, streams points. Uses apr_pkg, apr_build, apr_mac.
//
// Usage:
//   Write angle_deg and the axis through cfg_we/cfg_index/cfg_data while the
//   block is idle. Each write invalidates the rotation matrix.
//   Points enter on point/point_valid/point_stall, results leave on
//   result/result_valid/result_stall; one result per point, in order.
//   The first point after reset or after a write is held (point_stall high)
//   while the matrix is built by the sequencer around the serial divider
//   (nine entry divisions), the 24 CORDIC steps and the 32 square-root
//   steps. A zero axis finishes at the length check with an all-zero
//   matrix. Afterwards one point is taken every cycle while the output
//   stall does not hold the pipeline; a result is registered through the
//   product, sum/round and saturate stages before it can transfer.
//   When result_stall is high with a result waiting, the whole pipeline
//   holds and point_stall rises; nothing is dropped or repeated.
//   Reset clears the pipeline, the matrix and the configuration
//   (angle 0, axis 0,0,1).
module axis_angle_point_rotator_unit
    import apr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data,
    input  point_t      point,
    input  logic        point_valid,
    output logic        point_stall,
    output result_t     result,
    output logic        result_valid,
    input  logic        result_stall
);

    cfg_t             cfg_reg;
    logic             mat_ready;
    logic [8:0][31:0] rot;
    logic             advance;
    logic             take;
    logic             axis_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_deg <= '0;
            cfg_reg.axis_u    <= '0;
            cfg_reg.axis_v    <= '0;
            cfg_reg.axis_w    <= 16'sd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE:  cfg_reg.angle_deg <= cfg_data;
                REG_AXIS_U: cfg_reg.axis_u    <= cfg_data[15:0];
                REG_AXIS_V: cfg_reg.axis_v    <= cfg_data[15:0];
                REG_AXIS_W: cfg_reg.axis_w    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign axis_zero = (cfg_reg.axis_u == 16'sd0) && (cfg_reg.axis_v == 16'sd0)
                       && (cfg_reg.axis_w == 16'sd0);

    // hold everything while the finished result is not taken
    assign advance     = !(result_valid && result_stall);
    assign point_stall = !(mat_ready && advance);
    assign take        = point_valid && !point_stall;

    apr_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_write (cfg_we),
        .build_req (point_valid),
        .mat_ready (mat_ready),
        .rot       (rot)
    );

    apr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_take   (take),
        .pt        (point),
        .err       (axis_zero),
        .rot       (rot),
        .res_valid (result_valid),
        .res       (result)
    );

    a_take_needs_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> mat_ready)
        else $error("point transfer without a built matrix");

    a_write_drops_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !mat_ready)
        else $error("matrix still marked ready after a register write");

    a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.axis_error) |->
        (result.out_x == 32'sd0 && result.out_y == 32'sd0 && result.out_z == 32'sd0
         && !result.clipped))
        else $error("zero-axis result is not zero");

endmodule

@@ test/axis_angle_point_rotator_checker.sv @@
// Checker for the axis-angle point rotator: predicts each rotated point from
// the observed register writes and point transfers, and compares results.
// Depends on apr_pkg for payload types, register indexes and CORDIC tables.
module axis_angle_point_rotator_checker
    import apr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data,
    input  point_t      point,
    input  logic        point_valid,
    input  logic        point_stall,
    input  result_t     result,
    input  logic        result_valid,
    input  logic        result_stall,
    output int          fail_count,
    output int          pending
);

    localparam int FRAC = MATRIX_FRAC_BITS;

    logic signed [25:0] angle_q;
    logic signed [15:0] u_q;
    logic signed [15:0] v_q;
    logic signed [15:0] w_q;
    longint             rot[9];
    bit                 rot_valid;
    result_t            rotated_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic build_rotation();
        longint u, v, w, u2, v2, w2, len2, a, quad, r, z, x, y, dx, dy;
        longint sn, cs, t, sq, ss, e;
        longint num[9];
        longint lim;
        lim = longint'(1) << FRAC;
        u = u_q; v = v_q; w = w_q;
        u2 = u * u; v2 = v * v; w2 = w * w;
        len2 = u2 + v2 + w2;
        foreach (rot[k]) rot[k] = 0;
        rot_valid = 1;
        if (len2 == 0)
            return;
        a = longint'(angle_q) % 23592960;
        if (a < 0)
            a = a + 23592960;
        quad = a / 5898240;
        r = a % 5898240;
        z = (r * 1686629713 + 2949120) / 5898240;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(atan_entry(i[4:0]));
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(atan_entry(i[4:0]));
            end
        end
        case (quad)
            0: begin sn = y;  cs = x;  end
            1: begin sn = x;  cs = -y; end
            2: begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y; end
        endcase
        t = 1073741824 - cs;
        sq = longint'(int_sqrt(longint'(len2) << 32));
        ss = (sq * sn + 32768) >>> 16;
        num[0] = u2 * 1073741824 + (v2 + w2) * cs;
        num[1] = u * v * t - w * ss;
        num[2] = u * w * t + v * ss;
        num[3] = u * v * t + w * ss;
        num[4] = v2 * 1073741824 + (u2 + w2) * cs;
        num[5] = v * w * t - u * ss;
        num[6] = u * w * t - v * ss;
        num[7] = v * w * t + u * ss;
        num[8] = w2 * 1073741824 + (u2 + v2) * cs;
        for (int k = 0; k < 9; k++)
        begin
            e = round_div(num[k], longint'(len2) << (30 - FRAC));
            if (e > lim) e = lim;
            if (e < -lim) e = -lim;
            rot[k] = e;
        end
    endtask

    function automatic result_t rotate_point(input point_t p);
        result_t res;
        longint acc;
        longint rr;
        longint pc[3];
        res = '0;
        res.last_out = p.last_point;
        if (u_q == 0 && v_q == 0 && w_q == 0)
        begin
            res.axis_error = 1'b1;
            return res;
        end
        pc[0] = p.point_x; pc[1] = p.point_y; pc[2] = p.point_z;
        for (int j = 0; j < 3; j++)
        begin
            acc = pc[0] * rot[j] + pc[1] * rot[3 + j] + pc[2] * rot[6 + j];
            rr = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
            if (rr > 64'sd2147483647)
            begin
                rr = 64'sd2147483647; res.clipped = 1'b1;
            end
            if (rr < -64'sd2147483648)
            begin
                rr = -64'sd2147483648; res.clipped = 1'b1;
            end
            case (j)
                0: res.out_x = rr[31:0];
                1: res.out_y = rr[31:0];
                default: res.out_z = rr[31:0];
            endcase
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            angle_q = '0; u_q = '0; v_q = '0; w_q = 16'sd1;
            foreach (rot[k]) rot[k] = 0;
            rot_valid = 0;
            rotated_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("result transfer with no point outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = rotated_q.pop_front();
                    if (result !== exp_r)
                    begin
                        if (result.out_x !== exp_r.out_x)
                            $error("out_x expected %0d actual %0d", exp_r.out_x, result.out_x);
                        if (result.out_y !== exp_r.out_y)
                            $error("out_y expected %0d actual %0d", exp_r.out_y, result.out_y);
                        if (result.out_z !== exp_r.out_z)
                            $error("out_z expected %0d actual %0d", exp_r.out_z, result.out_z);
                        if (result.clipped !== exp_r.clipped)
                            $error("clipped expected %0b actual %0b",
                                   exp_r.clipped, result.clipped);
                        if (result.axis_error !== exp_r.axis_error)
                            $error("axis_error expected %0b actual %0b",
                                   exp_r.axis_error, result.axis_error);
                        if (result.last_out !== exp_r.last_out)
                            $error("last_out expected %0b actual %0b",
                                   exp_r.last_out, result.last_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (point_valid && !point_stall)
            begin
                if (!rot_valid)
                    build_rotation();
                rotated_q.push_back(rotate_point(point));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ANGLE:  angle_q = cfg_data;
                    REG_AXIS_U: u_q = cfg_data[15:0];
                    REG_AXIS_V: v_q = cfg_data[15:0];
                    REG_AXIS_W: w_q = cfg_data[15:0];
                    default: ;
                endcase
                rot_valid = 0;
            end
            pending <= rotated_q.size();
        end
    end

endmodule

@@ test/axis_angle_point_rotator_unit_tb.sv @@
// Top of the rotator testbench: clock, reset, register writes, point stimulus
// and receiver stalls. Uses apr_pkg and axis_angle_point_rotator_checker.
module axis_angle_point_rotator_unit_tb;
    import apr_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [25:0] cfg_data;
    point_t      point;
    logic        point_valid;
    logic        point_stall;
    result_t     result;
    logic        result_valid;
    logic        result_stall;
    logic        hold_off;
    int          fail_count;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    axis_angle_point_rotator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point        (point),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    axis_angle_point_rotator_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point        (point),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_off)
            result_stall <= 1'b1;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((point_valid && !point_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_point(input point_t p);
        while ($urandom_range(99) < idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (point_stall);
    endtask

    // Hold the sender off until every result is back, then let the block settle.
    task automatic drain();
        point_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [25:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_rotation(input logic [25:0] ang, input logic [15:0] u,
                                input logic [15:0] v, input logic [15:0] w);
        drain();
        write_reg(REG_ANGLE, ang);
        write_reg(REG_AXIS_U, {{10{u[15]}}, u});
        write_reg(REG_AXIS_V, {{10{v[15]}}, v});
        write_reg(REG_AXIS_W, {{10{w[15]}}, w});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(65535)) - 32768) <<< 8;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(131071)) - 65536);
        endcase
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return 16'($signed($urandom_range(6)) - 3);
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [25:0] rand_angle();
        case ($urandom_range(5))
            0: return 26'h1ffffff;
            1: return 26'h2000000;
            2: return $urandom_range(1) ? 26'd23592960 : -26'sd23592960;
            3: return 26'($urandom_range(8)) * 26'd5898240;
            default: return 26'($urandom());
        endcase
    endfunction

    task automatic send_random(input int n);
        point_t p;
        for (int i = 0; i < n; i++)
        begin
            p.point_x = rand_coord();
            p.point_y = rand_coord();
            p.point_z = rand_coord();
            p.last_point = ($urandom_range(7) == 0);
            send_point(p);
        end
    endtask

    initial
    begin
        point_t p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ANGLE;
        cfg_data = '0;
        point = '0;
        point_valid = 1'b0;
        hold_off = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset rotation (identity), then extremes of the fields.
        p = '{32'h7fffffff, 32'h80000000, 32'h00010000, 1'b0};
        send_point(p);
        p = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1};
        send_point(p);
        set_rotation(26'd5898240, 16'sd1, 16'sd1, 16'sd1);
        p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0};
        send_point(p);
        p = '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1};
        send_point(p);
        p = '{32'h00010000, 32'h0, 32'h0, 1'b0};
        send_point(p);
        // Zero axis gives zeros and the error flag.
        set_rotation(26'd1000, 16'sd0, 16'sd0, 16'sd0);
        p = '{32'h12345678, 32'h80000000, 32'h7fffffff, 1'b1};
        send_point(p);
        // Angles of a full turn and beyond the plus or minus 360 range.
        set_rotation(26'd23592960, 16'h8000, 16'h7fff, 16'h8000);
        send_random(3);
        set_rotation(26'h2000000, 16'sd3, -16'sd7, 16'sd0);
        send_random(3);
        set_rotation(26'h1ffffff, 16'h8000, 16'h0, 16'h0);
        send_random(3);
        set_rotation(-26'sd23592960, 16'h0, 16'h7fff, 16'h0);
        send_random(3);

        // Random phases across the idling modes.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_rotation(rand_angle(), rand_axis(), rand_axis(), rand_axis());
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            if (ph == 4)
            begin
                // Outlast the matrix build so the pipeline fills and backs up.
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (1500) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            send_random(45);
            // Drop the matrix mid-phase: new setting before the rest.
            set_rotation(rand_angle(), rand_axis(), rand_axis(), rand_axis());
            send_random(45);
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
